>>> hw/rtl/mrpn_pkg.sv
// Shared types, constants and the controller classification function of the RPN control filter.
package mrpn_pkg;

    // Field widths; group, channel, controller and data are fixed by the MIDI control change format.
    localparam int GROUP_W = 4;
    localparam int CHAN_W  = 4;
    localparam int CC_W    = 7;
    localparam int DATA_W  = 7;
    localparam int SEL_W   = 14;
    localparam int DROP_W  = 16;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_RACK16       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MGR_AUTO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MBR_AUTO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_MPE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_MGR_RNG = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_MBR_RNG = 3'd5;

    // Reset values of the live state.
    localparam logic              RST_MPE     = 1'b0;
    localparam logic [DATA_W-1:0] RST_MGR_RNG = 7'd2;
    localparam logic [DATA_W-1:0] RST_MBR_RNG = 7'd48;

    // Parameter selection constants.
    localparam logic [SEL_W-1:0] NULL_PARAM = 14'h3fff;
    localparam logic [SEL_W-1:0] LOW7_MASK  = 14'h007f;
    localparam logic [SEL_W-1:0] HIGH7_MASK = 14'h3f80;
    localparam logic [SEL_W-1:0] RPN_BEND   = 14'd0;
    localparam logic [SEL_W-1:0] RPN_MPE    = 14'd6;

    // Controller numbers that the parser acts on.
    localparam logic [CC_W-1:0] CC_DATA_ENTRY = 7'd6;
    localparam logic [CC_W-1:0] CC_NRPN_MSB   = 7'd99;
    localparam logic [CC_W-1:0] CC_NRPN_LSB   = 7'd98;
    localparam logic [CC_W-1:0] CC_RPN_MSB    = 7'd101;
    localparam logic [CC_W-1:0] CC_RPN_LSB    = 7'd100;

    localparam logic [DROP_W-1:0] DROP_MAX = 16'hffff;

    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [CHAN_W-1:0]  channel;
        logic [CC_W-1:0]    controller;
        logic [DATA_W-1:0]  value;
    } item_t;

    typedef struct packed {
        logic rack16;
        logic mgr_auto;
        logic mbr_auto;
    } cfg_t;

    typedef struct packed {
        logic [SEL_W-1:0] sel;
        logic             nrpn;
    } chan_entry_t;

    typedef struct packed {
        logic              en;
        logic [CHAN_W-1:0] channel;
        chan_entry_t       entry;
    } chan_wr_t;

    typedef struct packed {
        logic              mpe;
        logic [DATA_W-1:0] mgr_rng;
        logic [DATA_W-1:0] mbr_rng;
        logic [DROP_W-1:0] drops;
    } glob_t;

    // Controllers that only the manager channel may send while MPE is on.
    function automatic logic manager_only(input logic [CC_W-1:0] cc);
        logic hit;
        case (cc) inside
            7'd0, 7'd32, [7'd64:7'd69], 7'd120, 7'd121, [7'd123:7'd125]: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

>>> hw/rtl/mrpn_cfg_regs.sv
// Configuration register file of the RPN control filter.
module mrpn_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mrpn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrpn_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mrpn_pkg::cfg_t                     cfg
);

    logic rack16_reg;
    logic mgr_auto_reg;
    logic mbr_auto_reg;
    logic cfg_fire;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;

    // The initial range and MPE registers only name the reset values of the
    // live state, which are fixed at reset; their beats are taken and dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rack16_reg   <= 1'b0;
            mgr_auto_reg <= 1'b1;
            mbr_auto_reg <= 1'b1;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                mrpn_pkg::CFG_RACK16:   rack16_reg   <= cfg_data[0];
                mrpn_pkg::CFG_MGR_AUTO: mgr_auto_reg <= cfg_data[0];
                mrpn_pkg::CFG_MBR_AUTO: mbr_auto_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg.rack16   = rack16_reg;
    assign cfg.mgr_auto = mgr_auto_reg;
    assign cfg.mbr_auto = mbr_auto_reg;

endmodule

>>> hw/rtl/mrpn_chan_table.sv
// Per-channel parameter selection and NRPN mode registers.
module mrpn_chan_table #(
    parameter int CHANNELS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mrpn_pkg::CHAN_W-1:0]   rd_channel,
    output mrpn_pkg::chan_entry_t         rd_entry,
    input  mrpn_pkg::chan_wr_t            wr
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    mrpn_pkg::chan_entry_t table_reg [CHANNELS];

    logic             rd_in_range;
    logic             wr_in_range;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;

    assign rd_in_range = ({1'b0, rd_channel} < (mrpn_pkg::CHAN_W+1)'(CHANNELS));
    assign wr_in_range = ({1'b0, wr.channel} < (mrpn_pkg::CHAN_W+1)'(CHANNELS));
    assign rd_idx      = IDX_W'(rd_channel);
    assign wr_idx      = IDX_W'(wr.channel);

    // Out-of-range channels read as the null selection in RPN mode.
    always_comb
    begin
        if (rd_in_range)
        begin
            rd_entry = table_reg[rd_idx];
        end
        else
        begin
            rd_entry.sel  = mrpn_pkg::NULL_PARAM;
            rd_entry.nrpn = 1'b0;
        end
    end

    // Every entry resets to the null parameter in RPN mode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                table_reg[i].sel  <= mrpn_pkg::NULL_PARAM;
                table_reg[i].nrpn <= 1'b0;
            end
        end
        else if (wr.en && wr_in_range)
        begin
            table_reg[wr_idx] <= wr.entry;
        end
    end

endmodule

>>> hw/rtl/mrpn_filter_logic.sv
// Combinational acceptance check and RPN parser for one control change.
module mrpn_filter_logic #(
    parameter int CHANNELS = 16
) (
    input  mrpn_pkg::item_t        item,
    input  mrpn_pkg::cfg_t         cfg,
    input  mrpn_pkg::chan_entry_t  chan,
    input  mrpn_pkg::glob_t        glob,
    output mrpn_pkg::glob_t        glob_next,
    output mrpn_pkg::chan_wr_t     chan_wr,
    output logic                   accepted
);

    logic is_member;
    logic reject;
    logic parse_ok;
    logic is_manager_ch;
    logic data_ok;

    // Acceptance is judged on the MPE state before this item.
    assign is_manager_ch = (item.channel == '0);
    assign is_member     = glob.mpe && (item.group == '0) && !is_manager_ch;
    assign reject        = is_member && mrpn_pkg::manager_only(item.controller);
    assign accepted      = !reject;

    assign parse_ok = (item.group == '0)
                   && ({1'b0, item.channel} < (mrpn_pkg::CHAN_W+1)'(CHANNELS));
    assign data_ok  = !chan.nrpn && (chan.sel != mrpn_pkg::NULL_PARAM);

    always_comb
    begin
        glob_next     = glob;
        chan_wr.en      = 1'b0;
        chan_wr.channel = item.channel;
        chan_wr.entry   = chan;

        // Saturating drop counter.
        if (reject && (glob.drops != mrpn_pkg::DROP_MAX))
        begin
            glob_next.drops = glob.drops + 16'd1;
        end

        // Selection updates and data entry.
        if (parse_ok)
        begin
            case (item.controller)
                mrpn_pkg::CC_NRPN_MSB, mrpn_pkg::CC_RPN_MSB:
                begin
                    chan_wr.en          = 1'b1;
                    chan_wr.entry.sel   = (chan.sel & mrpn_pkg::LOW7_MASK)
                                        | {item.value, 7'd0};
                    chan_wr.entry.nrpn  = (item.controller == mrpn_pkg::CC_NRPN_MSB);
                end
                mrpn_pkg::CC_NRPN_LSB, mrpn_pkg::CC_RPN_LSB:
                begin
                    chan_wr.en          = 1'b1;
                    chan_wr.entry.sel   = (chan.sel & mrpn_pkg::HIGH7_MASK)
                                        | {7'd0, item.value};
                    chan_wr.entry.nrpn  = (item.controller == mrpn_pkg::CC_NRPN_LSB);
                end
                mrpn_pkg::CC_DATA_ENTRY:
                begin
                    if (data_ok && (chan.sel == mrpn_pkg::RPN_MPE))
                    begin
                        if (is_manager_ch && !cfg.rack16)
                        begin
                            glob_next.mpe = (item.value >= 7'd1) && (item.value <= 7'd15);
                        end
                    end
                    else if (data_ok && (chan.sel == mrpn_pkg::RPN_BEND))
                    begin
                        if (is_manager_ch)
                        begin
                            if (cfg.mgr_auto)
                            begin
                                glob_next.mgr_rng = item.value;
                            end
                        end
                        else if (cfg.mbr_auto)
                        begin
                            glob_next.mbr_rng = item.value;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> hw/rtl/midi_rpn_control_filter.sv
// Top level of the MIDI RPN/NRPN control filter.
//
// Input beats carry one MIDI control change (group, channel, controller,
// value) on a valid/ready channel. Each beat yields exactly one result beat:
// whether the change is passed on, plus the MPE enable, manager and member
// bend ranges and the saturating drop count as they stand after it.
// A beat is captured in an input register; once the result register is free or
// being taken, the filter logic reads the channel's selection, updates the
// state and loads the result register. Throughput is one beat per cycle while
// the receiver does not stall, set by the read-modify-write of the
// per-channel selection registers.
// When the receiver stalls, the result register holds and the input register
// keeps one more beat; ready drops only when both are full.
// The configuration channel is always ready and takes every write.
// Reset clears every channel to the null parameter in RPN mode, MPE off,
// manager range 2, member range 48 and the drop count to zero; it also
// restores the configuration registers to their defaults.
module midi_rpn_control_filter #(
    parameter int CHANNELS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mrpn_pkg::GROUP_W-1:0]        group,
    input  logic [mrpn_pkg::CHAN_W-1:0]         channel,
    input  logic [mrpn_pkg::CC_W-1:0]           controller,
    input  logic [mrpn_pkg::DATA_W-1:0]         value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                accepted,
    output logic                                mpe_on,
    output logic [mrpn_pkg::DATA_W-1:0]         manager_range,
    output logic [mrpn_pkg::DATA_W-1:0]         member_range,
    output logic [mrpn_pkg::DROP_W-1:0]         dropped_controls,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mrpn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mrpn_pkg::CFG_DATA_W-1:0]     cfg_data
);

    mrpn_pkg::cfg_t        cfg;
    mrpn_pkg::item_t       s1_item_reg;
    mrpn_pkg::chan_entry_t chan_rd;
    mrpn_pkg::chan_wr_t    chan_wr_raw;
    mrpn_pkg::chan_wr_t    chan_wr;
    mrpn_pkg::glob_t       glob_reg;
    mrpn_pkg::glob_t       glob_next;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic acc_next;
    logic acc_reg;
    logic in_fire;
    logic s1_fire;
    logic advance;

    // Configuration registers.
    mrpn_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake control of the two register stages.
    assign advance  = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.group      <= group;
            s1_item_reg.channel    <= channel;
            s1_item_reg.controller <= controller;
            s1_item_reg.value      <= value;
        end
    end

    // Per-channel selection registers.
    mrpn_chan_table #(
        .CHANNELS (CHANNELS)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_channel (s1_item_reg.channel),
        .rd_entry   (chan_rd),
        .wr         (chan_wr)
    );

    // Acceptance and parser logic.
    mrpn_filter_logic #(
        .CHANNELS (CHANNELS)
    ) u_logic (
        .item      (s1_item_reg),
        .cfg       (cfg),
        .chan      (chan_rd),
        .glob      (glob_reg),
        .glob_next (glob_next),
        .chan_wr   (chan_wr_raw),
        .accepted  (acc_next)
    );

    always_comb
    begin
        chan_wr    = chan_wr_raw;
        chan_wr.en = chan_wr_raw.en && s1_fire;
    end

    // Global state, updated once per processed beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glob_reg.mpe     <= mrpn_pkg::RST_MPE;
            glob_reg.mgr_rng <= mrpn_pkg::RST_MGR_RNG;
            glob_reg.mbr_rng <= mrpn_pkg::RST_MBR_RNG;
            glob_reg.drops   <= '0;
        end
        else if (s1_fire)
        begin
            glob_reg <= glob_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            acc_reg <= acc_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = acc_reg;
    assign mpe_on           = glob_reg.mpe;
    assign manager_range    = glob_reg.mgr_rng;
    assign member_range     = glob_reg.mbr_rng;
    assign dropped_controls = glob_reg.drops;

    // An empty result register never holds back the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with an empty result register");

    // The drop counter never goes backwards.
    a_drops_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (glob_reg.drops >= $past(glob_reg.drops)))
        else $error("drop counter decreased");

    // A rejected beat bumps the counter unless it is full.
    a_reject_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !acc_next) |=>
            ((glob_reg.drops == $past(glob_reg.drops) + 16'd1)
             || (glob_reg.drops == mrpn_pkg::DROP_MAX)))
        else $error("rejected control not counted");

    // MPE state moves only when a beat is processed.
    a_mpe_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(glob_reg.mpe))
        else $error("MPE state changed without a beat");

endmodule
